[rtl/core/sm3_hash_engine_unit_defines.svh]
// assertion macros for the sm3 hash engine
`ifndef SM3_HASH_ENGINE_UNIT_DEFINES_SVH
`define SM3_HASH_ENGINE_UNIT_DEFINES_SVH
// assert that a condition implies a consequence in the same cycle
`define SM3_ASSERT_IMP(label, clk, rst_n, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error(msg);
// assert that a condition implies a consequence in the following cycle
`define SM3_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error(msg);
`endif

[rtl/core/sm3_pkg.sv]
// ----------------------------------------------------------------------------
// sm3_pkg
// shared types, constants and round functions of the sm3 hash engine
// ----------------------------------------------------------------------------
`default_nettype none
package sm3_pkg;
  localparam logic [31:0] IV0 = 32'h7380166f;
  localparam logic [31:0] IV1 = 32'h4914b2b9;
  localparam logic [31:0] IV2 = 32'h172442d7;
  localparam logic [31:0] IV3 = 32'hda8a0600;
  localparam logic [31:0] IV4 = 32'ha96f30bc;
  localparam logic [31:0] IV5 = 32'h163138aa;
  localparam logic [31:0] IV6 = 32'he38dee4d;
  localparam logic [31:0] IV7 = 32'hb0fb0e4e;
  localparam logic [31:0] T_LOW = 32'h79cc4519;
  localparam logic [31:0] T_HIGH = 32'h7a879d8a;
  localparam logic [7:0] PAD_BYTE = 8'h80;

  // what follows a compression
  localparam logic [1:0] AFT_IDLE = 2'd0, AFT_PAD = 2'd1, AFT_LEN = 2'd2, AFT_OUT = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE, ST_RUN, ST_PAD, ST_LEN, ST_OUT
  } sm3_state_t;

  // controller to datapath
  typedef struct packed {
    logic put_byte;     // write the incoming byte
    logic put_pad;      // write 0x80 and clear tail of block
    logic clear_buf;    // zero the whole buffer
    logic put_len;      // write bit length into words 14 and 15
    logic start;        // load window and working words
    logic round;        // run one round
    logic fold;         // xor working words into chaining value
    logic shift_out;    // rotate chaining value for output
    logic reset_msg;    // back to initial vector
  } sm3_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic       last_round;
    logic       block_full;
    logic [5:0] byte_pos;
  } sm3_stat_t;

  function automatic logic [31:0] p0(input logic [31:0] x);
    p0 = x ^ {x[22:0], x[31:23]} ^ {x[14:0], x[31:15]};
  endfunction

  function automatic logic [31:0] p1(input logic [31:0] x);
    p1 = x ^ {x[16:0], x[31:17]} ^ {x[8:0], x[31:9]};
  endfunction

  function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] d;
    d = {x, x} << n;
    rotl = d[63:32];
  endfunction
endpackage
`default_nettype wire

[rtl/core/sm3_if.sv]
// ----------------------------------------------------------------------------
// sm3_in_if / sm3_out_if
// valid/ready channels of the sm3 hash engine
// ----------------------------------------------------------------------------
`default_nettype none
interface sm3_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       message_end;
  modport source (output valid, data_byte, byte_present, message_end, input ready);
  modport sink (input valid, data_byte, byte_present, message_end, output ready);
endinterface

interface sm3_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        final_word;
  modport source (output valid, digest_word, word_index, final_word, input ready);
  modport sink (input valid, digest_word, word_index, final_word, output ready);
endinterface
`default_nettype wire

[rtl/core/sm3_hash_engine_unit.sv]
// SM3 hash engine: message bytes enter one item at a time on the input
// channel; an item may carry a byte, an end marker, or both (byte first).
// Bytes are taken one per cycle while the block buffer fills. The
// 64th byte of a block starts a compression: a load step, 64 rounds at
// one round per cycle through the shared round unit, and a fold step;
// no item is taken meanwhile. At message end the padding takes one or
// two further blocks, then the digest leaves as eight 32-bit items, word
// 0 first, final_word set on word 7; after the eighth is taken the engine
// holds the initial vector again and accepts the next message.
// ----------------------------------------------------------------------------
// sm3_hash_engine_unit
// top level of the streaming sm3 hash engine
// ----------------------------------------------------------------------------
`default_nettype none
module sm3_hash_engine_unit
  import sm3_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  sm3_in_if.sink    in_ch,
  sm3_out_if.source out_ch
);
  sm3_cmd_t  cmd;
  sm3_stat_t stat;
  logic [2:0] idx;

  // sequencer
  sm3_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_ch.valid),
    .in_byte_present (in_ch.byte_present),
    .in_message_end  (in_ch.message_end),
    .in_ready        (in_ch.ready),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_idx         (idx),
    .stat            (stat),
    .cmd             (cmd)
  );

  // buffers, round unit and chaining value
  sm3_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .data_byte   (in_ch.data_byte),
    .stat        (stat),
    .digest_word (out_ch.digest_word)
  );

  // digest words leave straight from the chaining value register
  assign out_ch.word_index = idx;
  assign out_ch.final_word = (idx == 3'd7);
endmodule
`default_nettype wire

[rtl/core/sm3_datapath.sv]
// ----------------------------------------------------------------------------
// sm3_datapath
// block buffer, expansion window, working words and chaining value
// ----------------------------------------------------------------------------
`default_nettype none
module sm3_datapath
  import sm3_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire sm3_cmd_t    cmd,
  input  wire logic [7:0]  data_byte,
  output sm3_stat_t        stat,
  output logic [31:0]      digest_word
);
  logic [31:0] buf_r [16];
  logic [31:0] win_r [16];
  logic [31:0] ww_r [8];
  logic [31:0] cv_r [8];
  logic [63:0] len_r;
  logic [5:0]  pos_r;
  logic [5:0]  rnd_r;

  // window holds w[j..j+15] at round j; next word is w[j+16]
  logic [31:0] wnew, wj, wj1, a12, ss1, ss2, tt1, tt2, ff, gg, tj;
  always_comb begin
    wnew = p1(win_r[0] ^ win_r[7] ^ rotl(win_r[13], 5'd15))
         ^ rotl(win_r[3], 5'd7) ^ win_r[10];
    wj  = win_r[0];
    wj1 = win_r[4];
    tj  = (rnd_r < 6'd16) ? T_LOW : T_HIGH;
    if (rnd_r < 6'd16) begin
      ff = ww_r[0] ^ ww_r[1] ^ ww_r[2];
      gg = ww_r[4] ^ ww_r[5] ^ ww_r[6];
    end else begin
      ff = (ww_r[0] & ww_r[1]) | (ww_r[0] & ww_r[2]) | (ww_r[1] & ww_r[2]);
      gg = (ww_r[4] & ww_r[5]) | (~ww_r[4] & ww_r[6]);
    end
    a12 = rotl(ww_r[0], 5'd12);
    ss1 = rotl(a12 + ww_r[4] + rotl(tj, rnd_r[4:0]), 5'd7);
    ss2 = ss1 ^ a12;
    tt1 = ff + ww_r[3] + ss2 + (wj ^ wj1);
    tt2 = gg + ww_r[7] + ss1 + wj;
  end

  assign stat.last_round = (rnd_r == 6'd63);
  assign stat.block_full = (pos_r == 6'd63);
  assign stat.byte_pos   = pos_r;
  assign digest_word     = cv_r[0];

  always_ff @(posedge clk) begin
    if (cmd.put_byte) begin
      buf_r[pos_r[5:2]][(3 - pos_r[1:0]) * 8 +: 8] <= data_byte;
    end
    if (cmd.put_pad) begin
      for (int i = 0; i < 16; i++) begin
        for (int b = 0; b < 4; b++) begin
          if (i * 4 + b > 32'(pos_r)) buf_r[i][(3 - b) * 8 +: 8] <= 8'h00;
          else if (i * 4 + b == 32'(pos_r)) buf_r[i][(3 - b) * 8 +: 8] <= PAD_BYTE;
        end
      end
    end
    if (cmd.clear_buf) begin
      for (int i = 0; i < 16; i++) buf_r[i] <= '0;
    end
    if (cmd.put_len) begin
      buf_r[14] <= len_r[63:32];
      buf_r[15] <= len_r[31:0];
    end
    if (cmd.start) begin
      for (int i = 0; i < 16; i++) win_r[i] <= buf_r[i];
      for (int i = 0; i < 8; i++) ww_r[i] <= cv_r[i];
    end else if (cmd.round) begin
      for (int i = 0; i < 15; i++) win_r[i] <= win_r[i + 1];
      win_r[15] <= wnew;
      ww_r[0] <= tt1;
      ww_r[1] <= ww_r[0];
      ww_r[2] <= rotl(ww_r[1], 5'd9);
      ww_r[3] <= ww_r[2];
      ww_r[4] <= p0(tt2);
      ww_r[5] <= ww_r[4];
      ww_r[6] <= rotl(ww_r[5], 5'd19);
      ww_r[7] <= ww_r[6];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.reset_msg) begin
      cv_r  <= '{IV0, IV1, IV2, IV3, IV4, IV5, IV6, IV7};
      len_r <= '0;
      pos_r <= '0;
      rnd_r <= '0;
    end else begin
      if (cmd.put_byte) begin
        pos_r <= pos_r + 6'd1;
        len_r <= len_r + 64'd8;
      end
      if (cmd.start) rnd_r <= '0;
      else if (cmd.round) rnd_r <= rnd_r + 6'd1;
      if (cmd.fold) begin
        for (int i = 0; i < 8; i++) cv_r[i] <= cv_r[i] ^ ww_r[i];
      end else if (cmd.shift_out) begin
        for (int i = 0; i < 7; i++) cv_r[i] <= cv_r[i + 1];
        cv_r[7] <= cv_r[0];
      end
    end
  end
endmodule
`default_nettype wire

[rtl/core/sm3_ctrl.sv]
// ----------------------------------------------------------------------------
// sm3_ctrl
// sequencer for byte intake, compression, padding and digest output
// ----------------------------------------------------------------------------
`default_nettype none
module sm3_ctrl
  import sm3_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  input  wire logic      in_byte_present,
  input  wire logic      in_message_end,
  output logic           in_ready,
  output logic           out_valid,
  input  wire logic      out_ready,
  output logic [2:0]     out_idx,
  input  wire sm3_stat_t stat,
  output sm3_cmd_t       cmd
);
  sm3_state_t state_r, state_nxt;
  logic [1:0] after_r, after_nxt;  // 0 idle, 1 pad, 2 len, 3 out
  logic [2:0] idx_r, idx_nxt;
  logic       end_r, end_nxt;

  assign out_idx = idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      after_r <= AFT_IDLE;
      idx_r   <= '0;
      end_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      after_r <= after_nxt;
      idx_r   <= idx_nxt;
      end_r   <= end_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    after_nxt = after_r;
    idx_nxt   = idx_r;
    end_nxt   = end_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.put_byte = in_byte_present;
          if (in_byte_present && stat.block_full) begin
            state_nxt = ST_RUN;
            cmd.start = 1'b0;
            after_nxt = in_message_end ? AFT_PAD : AFT_IDLE;
            end_nxt   = 1'b1;
          end else if (in_message_end) begin
            state_nxt = ST_PAD;
          end
        end
      end
      ST_RUN: begin
        if (end_r) begin
          cmd.start = 1'b1;
          end_nxt   = 1'b0;
        end else begin
          cmd.round = 1'b1;
          if (stat.last_round) begin
            end_nxt = 1'b1;
            state_nxt = ST_OUT;
          end
        end
      end
      ST_PAD: begin
        cmd.put_pad = 1'b1;
        if (stat.byte_pos > 6'd55) begin
          state_nxt = ST_RUN;
          end_nxt   = 1'b1;
          after_nxt = AFT_LEN;
        end else begin
          state_nxt = ST_LEN;
        end
      end
      ST_LEN: begin
        cmd.put_len = 1'b1;
        state_nxt   = ST_RUN;
        end_nxt     = 1'b1;
        after_nxt   = AFT_OUT;
      end
      ST_OUT: begin
        // entered after the last round: fold first, then dispatch
        if (end_r) begin
          cmd.fold = 1'b1;
          end_nxt  = 1'b0;
          case (after_r)
            AFT_IDLE: state_nxt = ST_IDLE;
            AFT_PAD:  state_nxt = ST_PAD;
            AFT_LEN: begin
              cmd.clear_buf = 1'b1;
              state_nxt     = ST_LEN;
            end
            default: idx_nxt = '0;
          endcase
        end else begin
          out_valid = 1'b1;
          if (out_ready) begin
            cmd.shift_out = 1'b1;
            idx_nxt = idx_r + 3'd1;
            if (idx_r == 3'd7) begin
              cmd.shift_out = 1'b0;
              cmd.reset_msg = 1'b1;
              state_nxt     = ST_IDLE;
              after_nxt     = AFT_IDLE;
            end
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

[rtl/core/sm3_checker.sv]
// ----------------------------------------------------------------------------
// sm3_checker
// port level checks of the sm3 hash engine
// ----------------------------------------------------------------------------
`default_nettype none
`include "sm3_hash_engine_unit_defines.svh"
module sm3_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [2:0] word_index,
  input wire logic       final_word
);
  `SM3_ASSERT_IMP(a_no_overlap, clk, rst_n, out_valid, !in_ready, "input open during digest")
  `SM3_ASSERT_IMP(a_final, clk, rst_n, out_valid, final_word == (word_index == 3'd7), "final flag wrong")
  `SM3_ASSERT_NEXT(a_step, clk, rst_n, out_valid && out_ready && word_index != 3'd7, out_valid && word_index == $past(word_index) + 3'd1, "index skip")
  `SM3_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(word_index), "word dropped")
endmodule

bind sm3_hash_engine_unit sm3_checker u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .word_index (out_ch.word_index),
  .final_word (out_ch.final_word)
);
`default_nettype wire
